@@ rtl/core/wmd_pkg.sv @@
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared types, constants and helpers of the waveform min/max decimator.
// ----------------------------------------------------------------------------
package wmd_pkg;

  localparam int unsigned MAX_CHANNELS_DEF      = 8;
  localparam int unsigned MAX_FRAME_SAMPLES_DEF = 8192;
  localparam int unsigned MAX_COLUMNS_DEF       = 4096;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned Y_W       = 13;
  localparam int unsigned TDATA_W   = 48;
  localparam int unsigned CCOUNT_W  = 4;
  localparam int unsigned FSAMP_W   = 14;
  localparam int unsigned CCOL_W    = 13;
  localparam int unsigned HH_W      = 11;
  localparam int unsigned SPROD_W   = SAMPLE_W + HH_W + 1;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_FRAME_SAMPLES = 2'd1;
  localparam logic [1:0] REG_COLUMN_COUNT  = 2'd2;
  localparam logic [1:0] REG_HALF_HEIGHT   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_UPD,
    ST_SCALE_HI,
    ST_SCALE_LO,
    ST_SCALE_FIN,
    ST_OUT
  } wmd_state_e;

  // trunc(p / 32768) toward zero
  function automatic logic signed [Y_W-1:0] scale_round(input logic signed [SPROD_W-1:0] p);
    logic signed [SPROD_W-1:0] biased;
    biased = p[SPROD_W-1] ? p + SPROD_W'(32767) : p;
    return Y_W'(biased >>> 15);
  endfunction

endpackage

@@ rtl/core/wmd_ram.sv @@
// ----------------------------------------------------------------------------
// wmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wmd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/waveform_minmax_decimator.sv @@
// ----------------------------------------------------------------------------
// waveform_minmax_decimator
// Min/max peak decimation of interleaved audio frames for a waveform display.
// ----------------------------------------------------------------------------
// One input transaction is handled at a time. An item that ends no column goes
// from acceptance through the LOAD, DIV and UPD states back to IDLE; each
// result it causes adds the scaling states SCALE_HI, SCALE_LO and SCALE_FIN
// and then the OUT state, which waits until the sink is ready. The DIV state
// runs the bit-serial column divider, one quotient bit per cycle, followed
// by one shared scaling multiplier used once per output value. Per-channel
// running max/min live in a small RAM, read on acceptance and written back
// once per item. Results: tdata carries channel, column, y_high, y_low; tuser
// flags a single point; tlast marks the final result of an input sample.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator
  import wmd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS      = MAX_CHANNELS_DEF,
  parameter int unsigned MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int unsigned MAX_COLUMNS       = MAX_COLUMNS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // stream in
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [15:0]        s_tdata_i,   // [15:0] sample
  // stream out
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [TDATA_W-1:0] m_tdata_o,   // [2:0] channel, [14:3] column,
                                          // [27:15] y_high, [40:28] y_low
  output logic               m_tuser_o,   // [0] is_point
  output logic               m_tlast_o,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NchW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned IW    = $clog2(MAX_FRAME_SAMPLES);
  localparam int unsigned NsW   = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned NcW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned QW    = $clog2(MAX_COLUMNS);
  localparam int unsigned PW    = IW + NcW;
  localparam int unsigned CmpW  = (QW > COL_W) ? QW : COL_W;
  localparam int unsigned CntW  = $clog2(QW);
  localparam int unsigned RamW  = 2 * SAMPLE_W;

  // ---------------------------------------------------------------- config
  logic [CCOUNT_W-1:0] ccount_q;
  logic [FSAMP_W-1:0]  fsamp_q;
  logic [CCOL_W-1:0]   ccol_q;
  logic [HH_W-1:0]     hh_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccount_q <= CCOUNT_W'(2);
      fsamp_q  <= FSAMP_W'(1024);
      ccol_q   <= CCOL_W'(640);
      hh_q     <= HH_W'(100);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CHANNEL_COUNT: ccount_q <= pwdata[CCOUNT_W-1:0];
        REG_FRAME_SAMPLES: fsamp_q  <= pwdata[FSAMP_W-1:0];
        REG_COLUMN_COUNT:  ccol_q   <= pwdata[CCOL_W-1:0];
        REG_HALF_HEIGHT:   hh_q     <= pwdata[HH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHANNEL_COUNT: prdata = APB_DW'(ccount_q);
      REG_FRAME_SAMPLES: prdata = APB_DW'(fsamp_q);
      REG_COLUMN_COUNT:  prdata = APB_DW'(ccol_q);
      REG_HALF_HEIGHT:   prdata = APB_DW'(hh_q);
      default:           prdata = '0;
    endcase
  end

  // zero acts as one, too large saturates
  logic [NchW-1:0] nch;
  logic [NsW-1:0]  ns;
  logic [NcW-1:0]  nc;

  always_comb begin
    if (ccount_q == '0) nch = NchW'(1);
    else if (32'(ccount_q) > 32'(MAX_CHANNELS)) nch = NchW'(MAX_CHANNELS);
    else nch = NchW'(ccount_q);
    if (fsamp_q == '0) ns = NsW'(1);
    else if (32'(fsamp_q) > 32'(MAX_FRAME_SAMPLES)) ns = NsW'(MAX_FRAME_SAMPLES);
    else ns = NsW'(fsamp_q);
    if (ccol_q == '0) nc = NcW'(1);
    else if (32'(ccol_q) > 32'(MAX_COLUMNS)) nc = NcW'(MAX_COLUMNS);
    else nc = NcW'(ccol_q);
  end

  // ---------------------------------------------------------------- fsm
  wmd_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            two_q, two_d;
  logic            sel_q, sel_d;
  logic            in_acc, out_acc;
  logic            emit1, emit2;
  logic            ram_we;

  assign in_acc  = s_tvalid_i && s_tready_o;
  assign out_acc = m_tvalid_o && m_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) state_d = ST_LOAD;
      ST_LOAD:      state_d = ST_DIV;
      ST_DIV:       if (cnt_q == '0) state_d = ST_UPD;
      ST_UPD:       state_d = (emit1 || emit2) ? ST_SCALE_HI : ST_IDLE;
      ST_SCALE_HI:  state_d = ST_SCALE_LO;
      ST_SCALE_LO:  state_d = ST_SCALE_FIN;
      ST_SCALE_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) state_d = (two_q && !sel_q) ? ST_SCALE_HI : ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    ram_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: s_tready_o = 1'b1;
      ST_UPD:  ram_we     = 1'b1;
      ST_OUT:  m_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    two_d = two_q;
    sel_d = sel_q;
    if (state_q == ST_LOAD) cnt_d = CntW'(QW - 1);
    else if (state_q == ST_DIV) cnt_d = cnt_q - CntW'(1);
    if (state_q == ST_UPD) begin
      two_d = emit1 && emit2;
      sel_d = 1'b0;
    end else if (state_q == ST_OUT && out_acc) begin
      sel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      two_q   <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      two_q   <= two_d;
      sel_q   <= sel_d;
    end
  end

  // ---------------------------------------------------------------- position
  logic [ChW-1:0]   chan_q, chan_d;
  logic [IW-1:0]    samp_q, samp_d;
  logic [COL_W-1:0] cur_q, cur_d;
  logic [ChW-1:0]   c_in, c_q;
  logic [IW-1:0]    i_in, i_q;

  always_comb begin
    c_in = (32'(chan_q) >= 32'(nch)) ? ChW'(nch - NchW'(1)) : chan_q;
    i_in = (32'(samp_q) >= 32'(ns)) ? IW'(ns - NsW'(1)) : samp_q;
  end

  // ---------------------------------------------------------------- datapath
  logic signed [SAMPLE_W-1:0] v_q;
  logic signed [SAMPLE_W-1:0] rmax_q, rmin_q;
  logic [RamW-1:0]            ram_rdata;
  logic [PW-1:0]              cprod;
  logic [NsW-1:0]             rem_q, rem_d;
  logic [QW-1:0]              quo_q, quo_d;
  logic [NsW:0]               trial;
  logic                       ge;
  logic signed [SAMPLE_W-1:0] sw_max, sw_min, new_max, new_min;
  logic signed [SAMPLE_W-1:0] a_hi_q, a_lo_q, b_hi_q, b_lo_q;
  logic [COL_W-1:0]           a_col_q, b_col_q;
  logic signed [SAMPLE_W-1:0] op;
  logic signed [SPROD_W-1:0]  sprod, sprod_q;
  logic signed [Y_W-1:0]      yh_q, yl_q;
  logic                       first;

  assign cprod = PW'(i_q) * PW'(nc);

  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= (NsW+1)'(ns);
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (state_q == ST_LOAD) begin
      rem_d = NsW'(cprod >> QW);
      quo_d = cprod[QW-1:0];
    end else if (state_q == ST_DIV) begin
      rem_d = ge ? NsW'(trial - (NsW+1)'(ns)) : NsW'(trial);
      quo_d = {quo_q[QW-2:0], ge};
    end
  end

  assign first = (i_q == '0);
  assign emit1 = !first && (CmpW'(quo_q) != CmpW'(cur_q));
  assign emit2 = (32'(i_q) == 32'(ns) - 32'd1);

  always_comb begin
    sw_max = emit1 ? rmin_q : rmax_q;
    sw_min = emit1 ? rmax_q : rmin_q;
    if (first) begin
      new_max = v_q;
      new_min = v_q;
    end else begin
      new_max = (v_q > sw_max) ? v_q : sw_max;
      new_min = (v_q < sw_min) ? v_q : sw_min;
    end
  end

  always_comb begin
    chan_d = chan_q;
    samp_d = samp_q;
    cur_d  = cur_q;
    if (state_q == ST_UPD) begin
      if (32'(c_q) == 32'(nch) - 32'd1) begin
        chan_d = '0;
        if (emit2) begin
          samp_d = '0;
          cur_d  = '0;
        end else begin
          samp_d = i_q + IW'(1);
          cur_d  = COL_W'(quo_q);
        end
      end else begin
        chan_d = c_q + ChW'(1);
        samp_d = i_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      samp_q <= '0;
      cur_q  <= '0;
    end else begin
      chan_q <= chan_d;
      samp_q <= samp_d;
      cur_q  <= cur_d;
    end
  end

  assign op    = (state_q == ST_SCALE_HI) ? (sel_q ? b_hi_q : a_hi_q)
                                          : (sel_q ? b_lo_q : a_lo_q);
  assign sprod = op * $signed({1'b0, hh_q});

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q <= SAMPLE_W'(-$signed(s_tdata_i));
      c_q <= c_in;
      i_q <= i_in;
    end
    if (state_q == ST_LOAD) begin
      rmax_q <= ram_rdata[RamW-1:SAMPLE_W];
      rmin_q <= ram_rdata[SAMPLE_W-1:0];
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (state_q == ST_UPD) begin
      if (emit1) begin
        a_hi_q  <= rmax_q;
        a_lo_q  <= rmin_q;
        a_col_q <= cur_q;
      end else begin
        a_hi_q  <= new_max;
        a_lo_q  <= new_min;
        a_col_q <= COL_W'(quo_q);
      end
      b_hi_q  <= new_max;
      b_lo_q  <= new_min;
      b_col_q <= COL_W'(quo_q);
    end
    if (state_q == ST_SCALE_HI || state_q == ST_SCALE_LO) sprod_q <= sprod;
    if (state_q == ST_SCALE_LO) yh_q <= scale_round(sprod_q);
    if (state_q == ST_SCALE_FIN) yl_q <= scale_round(sprod_q);
  end

  wmd_ram #(
    .Width (RamW),
    .Depth (MAX_CHANNELS)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i ({new_max, new_min}),
    .re_i    (in_acc),
    .raddr_i (c_in),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- output
  assign m_tdata_o = {7'b0, yl_q, yh_q, (sel_q ? b_col_q : a_col_q), CHAN_W'(c_q)};
  assign m_tuser_o = (yh_q == yl_q);
  assign m_tlast_o = !(two_q && !sel_q);

  // ---------------------------------------------------------------- checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("input and output active together");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (32'(quo_q) < 32'(nc)))
    else $error("column beyond column count");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (32'(rem_q) < 32'(ns)))
    else $error("divider remainder out of range");

  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && !m_tlast_o) |=> (state_q == ST_SCALE_HI))
    else $error("second result not scheduled");

endmodule
